@@ src/lde_pkg.sv @@
package lde_pkg;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int POS_W    = 16;
  localparam int SUM_W    = 21;
  localparam int ANGLE_W  = 15;
  localparam int DIST_W   = 20;

  // CORDIC datapath widths: sums scaled by 2^16 plus gain headroom
  localparam int SCALE_SH = 16;
  localparam int CW       = 40;
  localparam int ZW       = 24;
  localparam int ATAN_W   = 20;
  localparam int TABLE_LEN = 24;
  localparam int IDX_W    = 5;

  // Distance multiply split into two halves of x
  localparam int MLO_W    = 20;
  localparam int MHI_W    = 19;
  localparam int KINV_W   = 24;

  localparam logic [SAMPLE_W-1:0]      THRESH_RESET = 12'd2048;
  localparam logic signed [SUM_W-1:0]  SUM_MAX      = 21'sd1048575;
  localparam logic signed [SUM_W-1:0]  SUM_MIN      = -21'sd1048576;
  localparam logic [DIST_W-1:0]        DIST_MAX     = 20'd1048575;
  localparam logic signed [ZW-1:0]     ANGLE_LIM    = 24'sd11520;
  localparam logic signed [ZW-1:0]     DEG180       = 24'sd2949120;
  localparam logic signed [ZW-1:0]     ANGLE_RND    = 24'sd128;
  localparam logic [KINV_W-1:0]        KINV_Q24     = 24'd10188014;

  // Scan-end sums handed from the front to the back
  typedef struct packed {
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
  } lde_sums_t;

  // Saturating accumulate of one position component
  function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [SUM_W-1:0] a,
      input logic signed [POS_W-1:0] b);
    logic signed [SUM_W:0] r;
    r = $signed({a[SUM_W-1], a}) + $signed({{(SUM_W+1-POS_W){b[POS_W-1]}}, b});
    if (r > $signed({SUM_MAX[SUM_W-1], SUM_MAX})) begin
      return SUM_MAX;
    end else if (r < $signed({SUM_MIN[SUM_W-1], SUM_MIN})) begin
      return SUM_MIN;
    end else begin
      return r[SUM_W-1:0];
    end
  endfunction

  // atan(2^-i) in degrees, Q14
  function automatic logic [ATAN_W-1:0] atan_q14(input logic [IDX_W-1:0] i);
    logic [ATAN_W-1:0] v;
    unique case (i)
      5'd0:  v = 20'd737280;
      5'd1:  v = 20'd435242;
      5'd2:  v = 20'd229970;
      5'd3:  v = 20'd116736;
      5'd4:  v = 20'd58595;
      5'd5:  v = 20'd29326;
      5'd6:  v = 20'd14667;
      5'd7:  v = 20'd7334;
      5'd8:  v = 20'd3667;
      5'd9:  v = 20'd1833;
      5'd10: v = 20'd917;
      5'd11: v = 20'd458;
      5'd12: v = 20'd229;
      5'd13: v = 20'd115;
      5'd14: v = 20'd57;
      5'd15: v = 20'd29;
      5'd16: v = 20'd14;
      5'd17: v = 20'd7;
      5'd18: v = 20'd4;
      5'd19: v = 20'd2;
      5'd20: v = 20'd1;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

endpackage

@@ src/line_direction_estimator.sv @@
// Line direction estimator. Each input item is one light-sensor channel:
// a 12-bit sample and the sensor position (Q2.13). Samples below
// white_threshold add the position to saturating 21-bit sums; the item with
// last_channel set closes the scan and yields one result item: the sum's
// direction in 1/64 degree, its magnitude in unsigned Q7.13 and a found flag (all
// zero for an empty sum). The front accumulator takes one item per cycle
// while full is low. Each closed scan then occupies the CORDIC back end for
// its load, one rotation per cycle, two multiply halves for the gain
// correction and the result write (steps capped at 24). A two-entry queue
// holds closed scans so that the front can keep taking items while the back
// end works; full rises only when both queue entries are waiting. The one-entry
// result register lets the back end finish the next scan before pop.
module line_direction_estimator #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lde_pkg::SAMPLE_W-1:0]        cfg_data,
  input  logic                                push,
  output logic                                full,
  input  logic [lde_pkg::SAMPLE_W-1:0]        sample,
  input  logic signed [lde_pkg::POS_W-1:0]    pos_x,
  input  logic signed [lde_pkg::POS_W-1:0]    pos_y,
  input  logic                                last_channel,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [lde_pkg::ANGLE_W-1:0]  angle,
  output logic [lde_pkg::DIST_W-1:0]          distance,
  output logic                                line_found
);

  logic               accept;
  logic               mid_push;
  logic               mid_full;
  logic               mid_valid;
  logic               mid_pop;
  lde_pkg::lde_sums_t mid_in;
  lde_pkg::lde_sums_t mid_out;

  assign cfg_ready = 1'b1;
  assign full      = mid_full;
  assign accept    = push && !mid_full;

  lde_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .sample       (sample),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .last_channel (last_channel),
    .mid_push     (mid_push),
    .mid_data     (mid_in)
  );

  lde_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (mid_push),
    .push_data (mid_in),
    .full      (mid_full),
    .pop       (mid_pop),
    .valid     (mid_valid),
    .pop_data  (mid_out)
  );

  lde_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .mid_valid  (mid_valid),
    .mid_data   (mid_out),
    .mid_pop    (mid_pop),
    .pop        (pop),
    .empty      (empty),
    .angle      (angle),
    .distance   (distance),
    .line_found (line_found)
  );

endmodule

@@ src/lde_front.sv @@
module lde_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [lde_pkg::SAMPLE_W-1:0]      cfg_data,
  input  logic                              accept,
  input  logic [lde_pkg::SAMPLE_W-1:0]      sample,
  input  logic signed [lde_pkg::POS_W-1:0]  pos_x,
  input  logic signed [lde_pkg::POS_W-1:0]  pos_y,
  input  logic                              last_channel,
  output logic                              mid_push,
  output lde_pkg::lde_sums_t                mid_data
);

  logic [lde_pkg::SAMPLE_W-1:0]     threshold;
  logic signed [lde_pkg::SUM_W-1:0] sum_x;
  logic signed [lde_pkg::SUM_W-1:0] sum_y;
  logic                             white;
  logic signed [lde_pkg::SUM_W-1:0] sum_x_next;
  logic signed [lde_pkg::SUM_W-1:0] sum_y_next;

  // Classify and accumulate
  always_comb begin
    white = sample < threshold;
    if (white) begin
      sum_x_next = lde_pkg::sat_add(sum_x, pos_x);
      sum_y_next = lde_pkg::sat_add(sum_y, pos_y);
    end else begin
      sum_x_next = sum_x;
      sum_y_next = sum_y;
    end
  end

  // Scan end hands the sums to the back
  assign mid_push       = accept && last_channel;
  assign mid_data.sum_x = sum_x_next;
  assign mid_data.sum_y = sum_y_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= lde_pkg::THRESH_RESET;
      sum_x     <= '0;
      sum_y     <= '0;
    end else begin
      if (cfg_valid) begin
        threshold <= cfg_data;
      end
      if (accept) begin
        if (last_channel) begin
          sum_x <= '0;
          sum_y <= '0;
        end else begin
          sum_x <= sum_x_next;
          sum_y <= sum_y_next;
        end
      end
    end
  end

endmodule

@@ src/lde_fifo.sv @@
module lde_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lde_pkg::lde_sums_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output lde_pkg::lde_sums_t pop_data
);

  // Two scans of slack between front and back
  lde_pkg::lde_sums_t slots [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  logic               do_push;
  logic               do_pop;

  assign full     = count == 2'd2;
  assign valid    = count != 2'd0;
  assign pop_data = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("scan queue count out of range");
  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
      (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("scan queue pointers disagree with count");
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
      (push && full && !pop) |=> full)
    else $error("scan queue lost fullness on a blocked push");

endmodule

@@ src/lde_back.sv @@
module lde_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                mid_valid,
  input  lde_pkg::lde_sums_t                  mid_data,
  output logic                                mid_pop,
  input  logic                                pop,
  output logic                                empty,
  output logic signed [lde_pkg::ANGLE_W-1:0]  angle,
  output logic [lde_pkg::DIST_W-1:0]          distance,
  output logic                                line_found
);

  localparam int STEPS_EFF = (CORDIC_STEPS > lde_pkg::TABLE_LEN) ?
                             lde_pkg::TABLE_LEN : CORDIC_STEPS;
  localparam logic [lde_pkg::IDX_W-1:0] LAST_STEP = lde_pkg::IDX_W'(STEPS_EFF - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ROT    = 3'd1;
  localparam logic [2:0] ST_MUL_LO = 3'd2;
  localparam logic [2:0] ST_MUL_HI = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;

  localparam int PLO_W = lde_pkg::MLO_W + lde_pkg::KINV_W;
  localparam int PHI_W = lde_pkg::MHI_W + lde_pkg::KINV_W;

  logic [2:0]                         state;
  logic [lde_pkg::IDX_W-1:0]          step;
  logic signed [lde_pkg::CW-1:0]      x;
  logic signed [lde_pkg::CW-1:0]      y;
  logic signed [lde_pkg::ZW-1:0]      z;
  logic                               is_zero;
  logic [PLO_W-1:0]                   p_lo;
  logic [PHI_W-1:0]                   p_hi;
  logic                               out_valid;

  logic signed [lde_pkg::CW-1:0]      sx;
  logic signed [lde_pkg::CW-1:0]      sy;
  logic signed [lde_pkg::CW-1:0]      xs;
  logic signed [lde_pkg::CW-1:0]      ys;
  logic signed [lde_pkg::ZW-1:0]      a_step;
  logic [lde_pkg::CW-2:0]             xc;
  logic [63:0]                        total;
  logic [23:0]                        dist_full;
  logic signed [lde_pkg::ZW-1:0]      ang_full;
  logic signed [lde_pkg::ANGLE_W-1:0] ang_sat;
  logic [lde_pkg::DIST_W-1:0]         dist_sat;
  logic                               out_free;

  // Scale the sums by 2^16
  always_comb begin
    sx = {{(lde_pkg::CW - lde_pkg::SUM_W - lde_pkg::SCALE_SH){mid_data.sum_x[lde_pkg::SUM_W-1]}},
          mid_data.sum_x, {lde_pkg::SCALE_SH{1'b0}}};
    sy = {{(lde_pkg::CW - lde_pkg::SUM_W - lde_pkg::SCALE_SH){mid_data.sum_y[lde_pkg::SUM_W-1]}},
          mid_data.sum_y, {lde_pkg::SCALE_SH{1'b0}}};
  end

  // One rotation step
  always_comb begin
    xs     = x >>> step;
    ys     = y >>> step;
    a_step = signed'({{(lde_pkg::ZW - lde_pkg::ATAN_W){1'b0}}, lde_pkg::atan_q14(step)});
  end

  // Scale correction and final rounding
  always_comb begin
    xc        = x[lde_pkg::CW-1] ? '0 : x[lde_pkg::CW-2:0];
    total     = {1'b0, p_hi, {lde_pkg::MLO_W{1'b0}}} + 64'(p_lo) + (64'd1 << 39);
    dist_full = total[63:40];
    dist_sat  = (dist_full > 24'(lde_pkg::DIST_MAX)) ? lde_pkg::DIST_MAX
                                                      : dist_full[lde_pkg::DIST_W-1:0];
    ang_full  = (z + lde_pkg::ANGLE_RND) >>> 8;
    if (ang_full > lde_pkg::ANGLE_LIM) begin
      ang_sat = lde_pkg::ANGLE_W'(lde_pkg::ANGLE_LIM);
    end else if (ang_full < -lde_pkg::ANGLE_LIM) begin
      ang_sat = lde_pkg::ANGLE_W'(-lde_pkg::ANGLE_LIM);
    end else begin
      ang_sat = ang_full[lde_pkg::ANGLE_W-1:0];
    end
  end

  assign out_free = !out_valid || pop;
  assign mid_pop  = (state == ST_IDLE) && mid_valid;
  assign empty    = !out_valid;

  // Sequencer: load, rotate, two multiply halves, write result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      // result register: set by a finished scan, cleared on pop
      if ((state == ST_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (mid_valid) begin
            step  <= '0;
            state <= ST_ROT;
          end
        end
        ST_ROT: begin
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            state <= ST_MUL_LO;
          end
        end
        ST_MUL_LO: state <= ST_MUL_HI;
        ST_MUL_HI: state <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (mid_valid) begin
          is_zero <= (mid_data.sum_x == '0) && (mid_data.sum_y == '0);
          if (sx[lde_pkg::CW-1]) begin
            x <= -sx;
            y <= -sy;
            z <= sy[lde_pkg::CW-1] ? -lde_pkg::DEG180 : lde_pkg::DEG180;
          end else begin
            x <= sx;
            y <= sy;
            z <= '0;
          end
        end
      end
      ST_ROT: begin
        if (y > 0) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + a_step;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - a_step;
        end
      end
      ST_MUL_LO: p_lo <= PLO_W'(xc[lde_pkg::MLO_W-1:0]) * PLO_W'(lde_pkg::KINV_Q24);
      ST_MUL_HI: p_hi <= PHI_W'(xc[lde_pkg::CW-2:lde_pkg::MLO_W]) * PHI_W'(lde_pkg::KINV_Q24);
      ST_FIN: begin
        if (out_free) begin
          angle      <= is_zero ? '0 : ang_sat;
          distance   <= is_zero ? '0 : dist_sat;
          line_found <= !is_zero;
        end
      end
      default: ;
    endcase
  end

  a_zero_result: assert property (@(posedge clk) disable iff (rst)
      (out_valid && !line_found) |-> (angle == '0 && distance == '0))
    else $error("empty scan produced a nonzero result");
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> (angle <= 15'sd11520 && angle >= -15'sd11520))
    else $error("angle outside clamp range");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
      (state == ST_ROT) |-> (step <= LAST_STEP))
    else $error("rotation step past the last one");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
      mid_pop |=> (state == ST_ROT))
    else $error("scan taken without starting rotation");

endmodule

@@ bench/tb.sv @@
module tb;

  localparam int STEPS         = 16;   // CORDIC rotations in the block (capped at 24)
  localparam int SETTLE_CYCLES = 40;   // back end drain before a threshold write
  localparam int STALL_LIMIT   = 4000; // cycles with no handshake before giving up
  localparam int QUIET_FROM    = 1500; // window of cycles with no random idling
  localparam int QUIET_TO      = 3000;

  // One pending item: a channel item, or a threshold write
  typedef struct packed {
    logic                             is_cfg;
    logic [lde_pkg::SAMPLE_W-1:0]     thr;
    logic [lde_pkg::SAMPLE_W-1:0]     sample;
    logic signed [lde_pkg::POS_W-1:0] px;
    logic signed [lde_pkg::POS_W-1:0] py;
    logic                             last;
  } chan_item_t;

  // One expected result item
  typedef struct packed {
    logic signed [lde_pkg::ANGLE_W-1:0] angle;
    logic [lde_pkg::DIST_W-1:0]         distance;
    logic                               found;
  } line_fix_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [lde_pkg::SAMPLE_W-1:0]        cfg_data = '0;
  logic                                push = 1'b0;
  logic                                full;
  logic [lde_pkg::SAMPLE_W-1:0]        sample = '0;
  logic signed [lde_pkg::POS_W-1:0]    pos_x = '0;
  logic signed [lde_pkg::POS_W-1:0]    pos_y = '0;
  logic                                last_channel = 1'b0;
  logic                                empty;
  logic                                pop = 1'b0;
  logic signed [lde_pkg::ANGLE_W-1:0]  angle;
  logic [lde_pkg::DIST_W-1:0]          distance;
  logic                                line_found;

  line_direction_estimator #(.CORDIC_STEPS(STEPS)) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .sample       (sample),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .last_channel (last_channel),
    .empty        (empty),
    .pop          (pop),
    .angle        (angle),
    .distance     (distance),
    .line_found   (line_found)
  );

  always #5 clk = ~clk;

  // atan(2^-i) in degrees, Q14
  int atan_tab [24] = '{737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
                        3667, 1833, 917, 458, 229, 115, 57, 29,
                        14, 7, 4, 2, 1, 0, 0, 0};

  chan_item_t                       scan_items[$];
  line_fix_t                        expected_fixes[$];
  logic [lde_pkg::SAMPLE_W-1:0]     white_thr;
  logic signed [lde_pkg::SUM_W-1:0] acc_x, acc_y;
  logic                item_taken = 1'b0;
  logic                cfg_taken = 1'b0;
  logic                stim_done = 1'b0;
  int                  cyc = 0;
  int                  errors = 0;
  int                  settle = 0;
  int                  idle_run = 0;

  // Saturate a widened sum back to the accumulator range
  function automatic logic signed [lde_pkg::SUM_W-1:0] clamp_sum(input longint v);
    if (v > 1048575) return 21'sd1048575;
    if (v < -1048576) return -21'sd1048576;
    return v[lde_pkg::SUM_W-1:0];
  endfunction

  // Direction and magnitude of the summed white positions
  function automatic line_fix_t vector_direction(input longint sx, input longint sy);
    longint x, y, z, xs, ys, a, d;
    line_fix_t f;
    f = '0;
    if (sx == 0 && sy == 0) return f;
    x = sx * 65536;
    y = sy * 65536;
    z = 0;
    // left half plane: rotate by 180 degrees first
    if (x < 0) begin
      z = (y >= 0) ? 180 * 16384 : -180 * 16384;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_tab[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_tab[i];
      end
    end
    a = (z + 128) >>> 8;
    if (a > 11520) a = 11520;
    if (a < -11520) a = -11520;
    if (x < 0) x = 0;
    // gain correction, 1/K in Q24, rounded
    d = (x * longint'(10188014) + (longint'(1) <<< 39)) >>> 40;
    if (d > 1048575) d = 1048575;
    f.angle = a[lde_pkg::ANGLE_W-1:0];
    f.distance = d[lde_pkg::DIST_W-1:0];
    f.found = 1'b1;
    return f;
  endfunction

  task automatic add_item(input int s, input int x, input int y, input bit l);
    chan_item_t it;
    it = '0;
    it.sample = s[lde_pkg::SAMPLE_W-1:0];
    it.px = x[lde_pkg::POS_W-1:0];
    it.py = y[lde_pkg::POS_W-1:0];
    it.last = l;
    scan_items = {scan_items, it};
  endtask

  task automatic add_cfg(input int thr);
    chan_item_t it;
    it = '0;
    it.is_cfg = 1'b1;
    it.thr = thr[lde_pkg::SAMPLE_W-1:0];
    scan_items = {scan_items, it};
  endtask

  function automatic int rand_pos();
    logic [31:0] r;
    r = $urandom;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 127) - 64;
    return int'($signed(r[lde_pkg::POS_W-1:0]));
  endfunction

  // Random scans, each closed by a last item, until n items are queued
  task automatic add_scans(input int thr, input int n);
    int added, kind, len, lo, hi, s, p, q;
    added = 0;
    while (added < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        // ordinary scan, mostly short, some long
        len = (kind < 70) ? $urandom_range(1, 24) : $urandom_range(25, 60);
        lo = (thr >= 2) ? thr - 2 : 0;
        hi = (thr <= 4094) ? thr + 1 : 4095;
        for (int i = 0; i < len; i++) begin
          s = $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(lo, hi);
          add_item(s, rand_pos(), rand_pos(), i == len - 1);
        end
        added += len;
      end else if (kind < 88) begin
        // same extreme position over and over: sums saturate
        len = $urandom_range(33, 40);
        p = $urandom_range(0, 2) == 0 ? 0 : ($urandom_range(0, 1) ? 32767 : -32768);
        q = $urandom_range(0, 2) == 0 ? 0 : ($urandom_range(0, 1) ? 32767 : -32768);
        for (int i = 0; i < len; i++) add_item(0, p, q, i == len - 1);
        added += len;
      end else if (kind < 95) begin
        // canceling pairs: zero sum with white samples
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          p = $urandom_range(0, 65534) - 32767;
          q = $urandom_range(0, 65534) - 32767;
          add_item($urandom_range(0, 4095) & 12'h0ff, p, q, 1'b0);
          add_item(0, -p, -q, i == len - 1);
        end
        added += 2 * len;
      end else begin
        add_item($urandom_range(0, 4095), rand_pos(), rand_pos(), 1'b1);
        added += 1;
      end
    end
  endtask

  // Predictor and result checker
  always @(posedge clk) begin
    line_fix_t want;
    if (rst) begin
      white_thr = lde_pkg::THRESH_RESET;
      acc_x = '0;
      acc_y = '0;
      item_taken <= 1'b0;
      cfg_taken <= 1'b0;
    end else begin
      cyc <= cyc + 1;
      item_taken <= push && !full;
      cfg_taken <= cfg_valid && cfg_ready;
      // outgoing result against the oldest expectation
      if (pop && !empty) begin
        if (expected_fixes.size() == 0) begin
          $error("unexpected result: angle %0d distance %0d line_found %0d",
                 angle, distance, line_found);
          errors++;
        end else begin
          want = expected_fixes.pop_front();
          if (angle !== want.angle) begin
            $error("angle: expected %0d, got %0d", want.angle, angle);
            errors++;
          end
          if (distance !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, distance);
            errors++;
          end
          if (line_found !== want.found) begin
            $error("line_found: expected %0d, got %0d", want.found, line_found);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) white_thr = cfg_data;
      // accumulate white channels, close the scan on last
      if (push && !full) begin
        if (sample < white_thr) begin
          acc_x = clamp_sum(longint'(acc_x) + longint'(pos_x));
          acc_y = clamp_sum(longint'(acc_y) + longint'(pos_y));
        end
        if (last_channel) begin
          expected_fixes = {expected_fixes, vector_direction(acc_x, acc_y)};
          acc_x = '0;
          acc_y = '0;
        end
      end
    end
  end

  // Driver: items and threshold writes from the pending queue, random idling
  always @(negedge clk) begin
    chan_item_t head;
    logic nx_push, nx_cfg, quiet;
    if (!rst) begin
      quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);
      nx_push = push && !item_taken;
      nx_cfg = cfg_valid && !cfg_taken;
      if (!nx_push && !nx_cfg) begin
        if (scan_items.size() == 0) begin
          stim_done <= 1'b1;
        end else begin
          head = scan_items[0];
          if (head.is_cfg) begin
            // write only with the back end drained
            if (expected_fixes.size() != 0) begin
              settle = 0;
            end else if (settle < SETTLE_CYCLES) begin
              settle++;
            end else begin
              nx_cfg = 1'b1;
              cfg_data <= head.thr;
              scan_items.delete(0);
              settle = 0;
            end
          end else if (quiet || $urandom_range(0, 99) >= 9) begin
            nx_push = 1'b1;
            sample <= head.sample;
            pos_x <= head.px;
            pos_y <= head.py;
            last_channel <= head.last;
            scan_items.delete(0);
          end
        end
      end
      push <= nx_push;
      cfg_valid <= nx_cfg;
      pop <= quiet || ($urandom_range(0, 99) >= 9);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (cfg_valid && cfg_ready) || (pop && !empty)) begin
        idle_run <= 0;
      end else if (idle_run >= STALL_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  initial begin
    // directed part at the reset threshold
    add_item(4095, 100, 200, 1'b1);        // nothing white: empty sum
    add_item(0, 32767, 32767, 1'b1);
    add_item(2047, -32768, -32768, 1'b1);  // left half plane, y negative
    add_item(0, -32768, 0, 1'b1);          // angle clamps near +180
    add_item(0, -32768, -1, 1'b1);
    add_item(0, -32768, 1, 1'b1);
    add_item(0, 0, 32767, 1'b1);
    add_item(0, 0, -32768, 1'b1);
    add_item(0, 32767, 0, 1'b1);
    add_item(2048, 5000, 5000, 1'b0);      // at threshold: not white
    add_item(2047, 1, -1, 1'b0);
    add_item(4095, -5, 7, 1'b1);           // last item not white
    add_item(100, 1234, -4321, 1'b0);      // canceling pair
    add_item(200, -1234, 4321, 1'b1);
    add_item(0, 1, 0, 1'b1);
    add_item(0, -1, 0, 1'b1);
    add_item(0, -1, -1, 1'b1);
    add_item(0, 21845, -21846, 1'b1);
    // random phases over several thresholds
    add_cfg(4095);
    add_scans(4095, 300);
    add_cfg(0);
    add_scans(0, 60);
    add_cfg(1);
    add_scans(1, 60);
    begin : rand_thr_a
      int t;
      t = $urandom_range(0, 4095);
      add_cfg(t);
      add_scans(t, 300);
      t = $urandom_range(0, 4095);
      add_cfg(t);
      add_scans(t, 250);
    end
    add_cfg(2048);
    add_scans(2048, 80);

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    while (!(stim_done && expected_fixes.size() == 0)) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
